// ===== hdl/uart_tx_rx_fifo_pair_core_defines.svh =====
// ----------------------------------------------------------------------------
// UART FIFO pair assertion macros
// Concurrent check wrappers, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef UART_TX_RX_FIFO_PAIR_CORE_DEFINES_SVH
`define UART_TX_RX_FIFO_PAIR_CORE_DEFINES_SVH

`ifndef SYNTH
// Property holds at every edge out of reset
`define UTRF_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("utrf check failed");
// Trigger implies consequence on the following edge
`define UTRF_ASSERT_NEXT(name, trig, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("utrf next-cycle check failed");
`else
`define UTRF_ASSERT(name, prop)
`define UTRF_ASSERT_NEXT(name, trig, cons)
`endif

`endif

// ===== hdl/utrf_pkg.sv =====
// ----------------------------------------------------------------------------
// UART FIFO pair package
// Depths, field widths, command codes and the structs passed between units.
// ----------------------------------------------------------------------------
`default_nettype none

package utrf_pkg;

  // FIFO depths
  localparam int TX_DEPTH = 16;
  localparam int RX_DEPTH = 16;

  // Pointer and level widths follow the depths
  localparam int TX_PTR_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int RX_PTR_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TX_CNT_W = $clog2(TX_DEPTH + 1);
  localparam int RX_CNT_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;

  // Fixed beat field widths
  localparam int CMD_W      = 3;
  localparam int BYTE_W     = 8;
  localparam int TX_LEVEL_W = 5;
  localparam int RX_LEVEL_W = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT       = 3'd0,
    CMD_GET       = 3'd1,
    CMD_TX_DONE   = 3'd2,
    CMD_RX_ARRIVE = 3'd3,
    CMD_RX_FLUSH  = 3'd4
  } cmd_t;

  // One accepted command beat, broadcast to both FIFO units
  typedef struct packed {
    logic              fire;
    cmd_t              cmd;
    logic [BYTE_W-1:0] data;
  } req_t;

  // Transmit unit result fields
  typedef struct packed {
    logic                  accepted;
    logic                  line_load;
    logic [BYTE_W-1:0]     line_byte;
    logic [TX_LEVEL_W-1:0] level;
    logic                  drive;
  } tx_res_t;

  // Receive unit result fields
  typedef struct packed {
    logic [BYTE_W-1:0]     read_byte;
    logic [RX_LEVEL_W-1:0] level;
  } rx_res_t;

endpackage

`default_nettype wire

// ===== hdl/utrf_cmd_if.sv =====
// ----------------------------------------------------------------------------
// UART FIFO pair command channel
// Valid/ready channel carrying one command and its data byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface utrf_cmd_if import utrf_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/utrf_res_if.sv =====
// ----------------------------------------------------------------------------
// UART FIFO pair result channel
// Valid/ready channel carrying one result beat per command.
// ----------------------------------------------------------------------------
`default_nettype none

interface utrf_res_if import utrf_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic                  accepted;
  logic [BYTE_W-1:0]     read_byte;
  logic                  line_load;
  logic [BYTE_W-1:0]     line_byte;
  logic [TX_LEVEL_W-1:0] tx_level;
  logic [RX_LEVEL_W-1:0] rx_level;
  logic                  driver_enable;

  modport source (
    output valid, output accepted, output read_byte, output line_load,
    output line_byte, output tx_level, output rx_level, output driver_enable,
    input ready
  );
  modport sink (
    input valid, input accepted, input read_byte, input line_load,
    input line_byte, input tx_level, input rx_level, input driver_enable,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/utrf_ram.sv =====
// ----------------------------------------------------------------------------
// UART FIFO pair generic RAM
// One write port, one read port with enable and registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module utrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/utrf_tx_side.sv =====
// ----------------------------------------------------------------------------
// UART FIFO pair transmit unit
// Transmit store, pointers, level and driver enable; feeds the line shifter.
// ----------------------------------------------------------------------------
`default_nettype none

module utrf_tx_side import utrf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  req_t    req,
  output tx_res_t res
);

  localparam logic [TX_PTR_W-1:0] PtrLast = TX_PTR_W'(TX_DEPTH - 1);
  localparam logic [TX_CNT_W-1:0] CntFull = TX_CNT_W'(TX_DEPTH);

  logic [TX_PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [TX_PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [TX_CNT_W-1:0] count, count_next, count_dec;
  logic                drive, drive_next;
  logic                accepted, accepted_next;
  logic                line_load, line_load_next;
  logic                from_ram, from_ram_next;
  logic [BYTE_W-1:0]   line_data;
  logic [BYTE_W-1:0]   ram_q;
  logic                full;
  logic                ram_we;
  logic                ram_re;

  function automatic logic [TX_PTR_W-1:0] wrap_ptr(input logic [TX_PTR_W-1:0] p);
    return (p == PtrLast) ? '0 : p + 1'b1;
  endfunction

  assign full      = (count == CntFull);
  assign count_dec = (count != '0) ? count - 1'b1 : '0;
  assign ram_we    = req.fire && (req.cmd == CMD_PUT) && !full;
  assign ram_re    = req.fire && (req.cmd == CMD_TX_DONE);

  // Decode the command into next pointer, level and line state
  always_comb begin
    wr_ptr_next    = wr_ptr;
    rd_ptr_next    = rd_ptr;
    count_next     = count;
    drive_next     = drive;
    accepted_next  = 1'b0;
    line_load_next = 1'b0;
    from_ram_next  = 1'b0;
    unique case (req.cmd)
      CMD_PUT: begin
        if (!full) begin
          drive_next    = 1'b1;
          wr_ptr_next   = wrap_ptr(wr_ptr);
          count_next    = count + 1'b1;
          accepted_next = 1'b1;
          // Idle line: the new byte goes straight out
          if (count == '0) begin
            line_load_next = 1'b1;
            rd_ptr_next    = wrap_ptr(rd_ptr);
          end
        end
      end
      CMD_TX_DONE: begin
        count_next = count_dec;
        if (count_dec != '0) begin
          line_load_next = 1'b1;
          from_ram_next  = 1'b1;
          rd_ptr_next    = wrap_ptr(rd_ptr);
        end else begin
          drive_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Hold control state; advance on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
      drive     <= 1'b0;
      accepted  <= 1'b0;
      line_load <= 1'b0;
      from_ram  <= 1'b0;
    end else if (req.fire) begin
      wr_ptr    <= wr_ptr_next;
      rd_ptr    <= rd_ptr_next;
      count     <= count_next;
      drive     <= drive_next;
      accepted  <= accepted_next;
      line_load <= line_load_next;
      from_ram  <= from_ram_next;
    end
  end

  // Capture the put byte for the idle-line bypass
  always_ff @(posedge clk) begin
    if (req.fire) begin
      line_data <= req.data;
    end
  end

  utrf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TX_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr),
    .wdata (req.data),
    .re    (ram_re),
    .raddr (rd_ptr),
    .rdata (ram_q)
  );

  // Select the line byte from the store or the bypass
  always_comb begin
    res.accepted  = accepted;
    res.line_load = line_load;
    res.line_byte = line_load ? (from_ram ? ram_q : line_data) : '0;
    res.level     = TX_LEVEL_W'(count);
    res.drive     = drive;
  end

endmodule

`default_nettype wire

// ===== hdl/utrf_rx_side.sv =====
// ----------------------------------------------------------------------------
// UART FIFO pair receive unit
// Receive store, pointers and level; one slot always stays free.
// ----------------------------------------------------------------------------
`default_nettype none

module utrf_rx_side import utrf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  req_t    req,
  output rx_res_t res
);

  localparam logic [RX_PTR_W-1:0] PtrLast = RX_PTR_W'(RX_DEPTH - 1);

  logic [RX_PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [RX_PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [RX_CNT_W-1:0] count, count_next;
  logic                hit, hit_next;
  logic [RX_PTR_W-1:0] wr_adv;
  logic [BYTE_W-1:0]   ram_q;
  logic                ram_we;
  logic                ram_re;

  function automatic logic [RX_PTR_W-1:0] wrap_ptr(input logic [RX_PTR_W-1:0] p);
    return (p == PtrLast) ? '0 : p + 1'b1;
  endfunction

  assign wr_adv = wrap_ptr(wr_ptr);
  assign ram_we = req.fire && (req.cmd == CMD_RX_ARRIVE);
  assign ram_re = req.fire && (req.cmd == CMD_GET) && (count != '0);

  // Decode the command into next pointer and level state
  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    hit_next    = 1'b0;
    unique case (req.cmd)
      CMD_GET: begin
        if (count != '0) begin
          hit_next    = 1'b1;
          rd_ptr_next = wrap_ptr(rd_ptr);
          count_next  = count - 1'b1;
        end
      end
      CMD_RX_ARRIVE: begin
        // Drop the byte when the last free slot would be taken
        if (wr_adv != rd_ptr) begin
          wr_ptr_next = wr_adv;
          count_next  = count + 1'b1;
        end
      end
      CMD_RX_FLUSH: begin
        count_next  = '0;
        rd_ptr_next = wr_ptr;
      end
      default: begin
      end
    endcase
  end

  // Hold control state; advance on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      hit    <= 1'b0;
    end else if (req.fire) begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
      hit    <= hit_next;
    end
  end

  utrf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RX_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr),
    .wdata (req.data),
    .re    (ram_re),
    .raddr (rd_ptr),
    .rdata (ram_q)
  );

  // Return zero on a get from an empty FIFO and after any other command
  always_comb begin
    res.read_byte = hit ? ram_q : '0;
    res.level     = RX_LEVEL_W'(count);
  end

endmodule

`default_nettype wire

// ===== hdl/uart_tx_rx_fifo_pair_core.sv =====
// Result: a result beat is valid in the cycle after its command beat is accepted.
// Throughput: one command per cycle; each command makes at most one store access whose
// registered read feeds the result directly, so nothing stalls but the sink.
// Reset: rst clears pointers, levels, the driver enable and the result valid;
// the two byte stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// UART FIFO pair core
// Transmit and receive FIFOs behind a command channel and a result channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "uart_tx_rx_fifo_pair_core_defines.svh"

module uart_tx_rx_fifo_pair_core import utrf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  utrf_cmd_if.sink   cmd_ch,
  utrf_res_if.source res_ch
);

  logic    res_valid;
  logic    fire;
  req_t    req;
  tx_res_t tx_res;
  rx_res_t rx_res;

  // Take a new beat whenever the result register is empty or draining
  assign cmd_ch.ready = !res_valid || res_ch.ready;
  assign fire         = cmd_ch.valid && cmd_ch.ready;

  always_comb begin
    req.fire = fire;
    req.cmd  = cmd_t'(cmd_ch.command);
    req.data = cmd_ch.data_byte;
  end

  // Hold the result valid until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd_ch.ready) begin
      res_valid <= cmd_ch.valid;
    end
  end

  utrf_tx_side u_tx (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (tx_res)
  );

  utrf_rx_side u_rx (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (rx_res)
  );

  // Drive the result beat
  always_comb begin
    res_ch.valid         = res_valid;
    res_ch.accepted      = tx_res.accepted;
    res_ch.read_byte     = rx_res.read_byte;
    res_ch.line_load     = tx_res.line_load;
    res_ch.line_byte     = tx_res.line_byte;
    res_ch.tx_level      = tx_res.level;
    res_ch.rx_level      = rx_res.level;
    res_ch.driver_enable = tx_res.drive;
  end

  // Driver enable tracks a nonzero transmit level
  `UTRF_ASSERT(a_drive_level, tx_res.drive == (tx_res.level != '0))
  // A byte is only handed to the line while driving
  `UTRF_ASSERT(a_load_drive, !tx_res.line_load || tx_res.drive)
  // A put into a full transmit FIFO is refused
  `UTRF_ASSERT_NEXT(a_full_refuse,
    fire && (req.cmd == CMD_PUT) && (tx_res.level == TX_LEVEL_W'(TX_DEPTH)),
    !tx_res.accepted)
  // Transmit level never exceeds the depth
  `UTRF_ASSERT(a_tx_bound, tx_res.level <= TX_LEVEL_W'(TX_DEPTH))

endmodule

`default_nettype wire
